/* design/skt_pkg.sv */
package skt_pkg;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_LOOKUP = 2'd1,
        MODE_UPDATE = 2'd2,
        MODE_DELETE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp_res;

    localparam int unsigned KEY_W   = 32;
    localparam int unsigned PAY_W   = 32;
    localparam int unsigned POS_W   = 6;
    localparam int unsigned COUNT_W = 7;

endpackage

/* design/skt_ram.sv */
module skt_ram #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [skt_pkg::KEY_W-1:0]     i_wkey,
    input  logic [skt_pkg::PAY_W-1:0]     i_wpay,
    input  logic [AW-1:0]                 i_raddr,
    output logic [skt_pkg::KEY_W-1:0]     o_rkey,
    output logic [skt_pkg::PAY_W-1:0]     o_rpay
);

    logic [skt_pkg::KEY_W-1:0] r_key_mem [DEPTH];
    logic [skt_pkg::PAY_W-1:0] r_pay_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_key_mem[i_waddr] <= i_wkey;
            r_pay_mem[i_waddr] <= i_wpay;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rkey <= r_key_mem[i_raddr];
        o_rpay <= r_pay_mem[i_raddr];
    end

endmodule

/* design/skt_cmp.sv */
module skt_cmp (
    input  logic [skt_pkg::KEY_W-1:0] i_a,
    input  logic [skt_pkg::KEY_W-1:0] i_b,
    output skt_pkg::t_cmp_res         o_res
);

    always_comb begin
        o_res.lt = $signed(i_a) < $signed(i_b);
        o_res.eq = i_a == i_b;
    end

endmodule

/* design/sorted_key_table.sv */
// Sorted key table: up to TABLE_DEPTH entries of signed 32-bit key plus 32-bit payload, kept in
// ascending key order in a single-port-read, single-port-write RAM. One beat at a time: the
// block takes a beat, drops tready, and returns one result beat. Lookup and update use a binary
// search, all through one shared key comparator and the one RAM read port. Insert and delete
// then move entries one by one (count-p for insert, count-p-1 for delete), each move a RAM
// read followed by a write. A finished result waits in the output register while the next
// beat may already be accepted.
module sorted_key_table #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // key[31:0], payload[63:32]
    input  logic [1:0]  s_axis_tuser,   // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // position[5:0], found_payload[37:6],
                                        // entry_count[44:38], zero fill
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SRD   = 7'b0000010,
        S_SCMP  = 7'b0000100,
        S_CHK   = 7'b0001000,
        S_SHIFT = 7'b0010000,
        S_PUT   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    skt_pkg::t_mode   r_mode, n_mode;
    skt_pkg::t_status r_status, n_status;
    logic [skt_pkg::KEY_W-1:0] r_key, n_key;
    logic [skt_pkg::PAY_W-1:0] r_pay, n_pay;
    logic [skt_pkg::PAY_W-1:0] r_rpay, n_rpay;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_mid, n_mid;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_count, n_count;
    logic          r_wpend, n_wpend;
    logic [AW-1:0] r_waddr, n_waddr;

    logic                      r_m_valid, n_m_valid;
    skt_pkg::t_status          r_m_status, n_m_status;
    logic [skt_pkg::POS_W-1:0]   r_m_pos, n_m_pos;
    logic [skt_pkg::PAY_W-1:0]   r_m_pay, n_m_pay;
    logic [skt_pkg::COUNT_W-1:0] r_m_cnt, n_m_cnt;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [skt_pkg::KEY_W-1:0] ram_wkey;
    logic [skt_pkg::PAY_W-1:0] ram_wpay;
    logic [AW-1:0]             ram_raddr;
    logic [skt_pkg::KEY_W-1:0] ram_rkey;
    logic [skt_pkg::PAY_W-1:0] ram_rpay;
    skt_pkg::t_cmp_res         cmp;

    logic          s_beat;
    logic          found;
    logic [CW-1:0] mid_calc;

    skt_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wkey  (ram_wkey),
        .i_wpay  (ram_wpay),
        .i_raddr (ram_raddr),
        .o_rkey  (ram_rkey),
        .o_rpay  (ram_rpay)
    );

    skt_cmp u_cmp (
        .i_a   (ram_rkey),
        .i_b   (r_key),
        .o_res (cmp)
    );

    assign s_axis_tready = r_state == S_IDLE;
    assign s_beat        = s_axis_tvalid && s_axis_tready;
    assign mid_calc      = r_lo + ((r_hi - r_lo) >> 1);
    assign found         = (r_lo < r_count) && cmp.eq;

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tdata  = {3'b000, r_m_cnt, r_m_pay, r_m_pos};

    // write port: pending shift move first, else the new or updated entry
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_waddr;
        ram_wkey  = ram_rkey;
        ram_wpay  = ram_rpay;
        if (r_wpend) begin
            ram_we = 1'b1;
        end else if (r_state == S_PUT) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(r_lo);
            ram_wkey  = r_key;
            ram_wpay  = r_pay;
        end
    end

    always_comb begin
        case (r_state)
            S_SRD: begin
                ram_raddr = (r_lo < r_hi) ? AW'(mid_calc) : AW'(r_lo);
            end
            S_SHIFT: begin
                ram_raddr = (r_mode == skt_pkg::MODE_INSERT) ? AW'(r_idx - CW'(1))
                                                              : AW'(r_idx + CW'(1));
            end
            default: begin
                ram_raddr = AW'(r_lo);
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_status   = r_status;
        n_key      = r_key;
        n_pay      = r_pay;
        n_rpay     = r_rpay;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_mid      = r_mid;
        n_idx      = r_idx;
        n_count    = r_count;
        n_wpend    = 1'b0;
        n_waddr    = r_waddr;
        n_m_valid  = r_m_valid && !m_axis_tready;
        n_m_status = r_m_status;
        n_m_pos    = r_m_pos;
        n_m_pay    = r_m_pay;
        n_m_cnt    = r_m_cnt;

        case (r_state)
            S_IDLE: begin
                if (s_beat) begin
                    n_mode   = skt_pkg::t_mode'(s_axis_tuser);
                    n_key    = s_axis_tdata[31:0];
                    n_pay    = s_axis_tdata[63:32];
                    n_status = skt_pkg::ST_OK;
                    n_rpay   = '0;
                    n_lo     = '0;
                    n_hi     = r_count;
                    if (skt_pkg::t_mode'(s_axis_tuser) == skt_pkg::MODE_INSERT &&
                        r_count >= CW'(TABLE_DEPTH)) begin
                        n_status = skt_pkg::ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_SRD;
                    end
                end
            end
            S_SRD: begin
                n_mid   = mid_calc;
                n_state = (r_lo < r_hi) ? S_SCMP : S_CHK;
            end
            S_SCMP: begin
                if (cmp.lt) begin
                    n_lo = r_mid + CW'(1);
                end else begin
                    n_hi = r_mid;
                end
                n_state = S_SRD;
            end
            S_CHK: begin
                case (r_mode)
                    skt_pkg::MODE_INSERT: begin
                        if (found) begin
                            n_status = skt_pkg::ST_DUPLICATE;
                            n_state  = S_DONE;
                        end else begin
                            n_rpay  = r_pay;
                            n_idx   = r_count;
                            n_state = S_SHIFT;
                        end
                    end
                    skt_pkg::MODE_LOOKUP: begin
                        n_status = found ? skt_pkg::ST_OK : skt_pkg::ST_NOT_FOUND;
                        n_rpay   = ram_rpay;
                        n_state  = S_DONE;
                    end
                    skt_pkg::MODE_UPDATE: begin
                        n_status = found ? skt_pkg::ST_OK : skt_pkg::ST_NOT_FOUND;
                        n_rpay   = r_pay;
                        n_state  = found ? S_PUT : S_DONE;
                    end
                    default: begin
                        n_status = found ? skt_pkg::ST_OK : skt_pkg::ST_NOT_FOUND;
                        n_rpay   = ram_rpay;
                        n_idx    = r_lo;
                        n_state  = found ? S_SHIFT : S_DONE;
                    end
                endcase
            end
            S_SHIFT: begin
                if (r_mode == skt_pkg::MODE_INSERT) begin
                    if (r_idx > r_lo) begin
                        n_wpend = 1'b1;
                        n_waddr = AW'(r_idx);
                        n_idx   = r_idx - CW'(1);
                    end else begin
                        n_state = S_PUT;
                    end
                end else begin
                    if (r_idx + CW'(1) < r_count) begin
                        n_wpend = 1'b1;
                        n_waddr = AW'(r_idx);
                        n_idx   = r_idx + CW'(1);
                    end else begin
                        n_count = r_count - CW'(1);
                        n_state = S_DONE;
                    end
                end
            end
            S_PUT: begin
                if (r_mode == skt_pkg::MODE_INSERT) begin
                    n_count = r_count + CW'(1);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid  = 1'b1;
                    n_m_status = r_status;
                    n_m_pos    = (r_status == skt_pkg::ST_OK) ? skt_pkg::POS_W'(r_lo) : '0;
                    n_m_pay    = (r_status == skt_pkg::ST_OK) ? r_rpay : '0;
                    n_m_cnt    = skt_pkg::COUNT_W'(r_count);
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_wpend   <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_wpend   <= n_wpend;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_status   <= n_status;
        r_key      <= n_key;
        r_pay      <= n_pay;
        r_rpay     <= n_rpay;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_idx      <= n_idx;
        r_waddr    <= n_waddr;
        r_m_status <= n_m_status;
        r_m_pos    <= n_m_pos;
        r_m_pay    <= n_m_pay;
        r_m_cnt    <= n_m_cnt;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_SHIFT || r_state == S_PUT))
        else $error("table write outside shift or put");

    a_beat_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_beat |=> r_state != S_IDLE)
        else $error("accepted beat did not start work");

    a_count_moves_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> ($past(r_state) == S_PUT || $past(r_state) == S_SHIFT))
        else $error("entry count changed outside insert or delete");

endmodule
